[design/amr_grid_hash_remap_assert.svh]
// Assertion macros shared by the remap block.
`ifndef AMR_GRID_HASH_REMAP_ASSERT_SVH
`define AMR_GRID_HASH_REMAP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define AMR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define AMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/amr_pkg.sv]
// Shared types and constants of the grid remap block.
package amr_pkg;

  localparam int unsigned BASE_SIZE   = 16;
  localparam int unsigned MAX_LEVEL   = 2;
  localparam int unsigned VALUE_BITS  = 32;

  localparam int unsigned FINE_SIDE   = BASE_SIZE << MAX_LEVEL;
  localparam int unsigned STORE_DEPTH = FINE_SIDE * FINE_SIDE;
  localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned FINE_W      = (FINE_SIDE > 1) ? $clog2(FINE_SIDE) : 1;
  localparam int unsigned SHIFT_W     = 6 + MAX_LEVEL;
  localparam int unsigned LVL_W       = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL + 1) : 1;
  localparam int unsigned STACK_DEPTH = (MAX_LEVEL > 0) ? MAX_LEVEL : 1;
  localparam int unsigned DEPTH_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SUM_W       = VALUE_BITS + 2;

  // Request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         col;
    logic [5:0]         row;
    logic [2:0]         cell_level;
    logic signed [31:0] cell_value;
  } amr_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } amr_out_t;

  typedef struct packed {
    logic                         valid;
    logic [LVL_W-1:0]             level;
    logic signed [VALUE_BITS-1:0] value;
  } amr_entry_t;

endpackage

[design/amr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module amr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [WIDTH-1:0]                 wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic [WIDTH-1:0]                 rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

[design/amr_grid_hash_remap.sv]
// Top level of the adaptive-mesh grid remap block.
// The block keeps one entry per fine-grid position in a single RAM with one
// write and one registered read port, and serves one transaction at a time.
// A load writes the store as it is taken and then hands over its status. A
// clear sweeps the whole store, one entry a cycle; the same sweep runs once
// after reset before the first transaction is taken. A query probes from its
// own level towards coarser levels (up to MAX_LEVEL + 1 probes), then reads
// and averages subcells where the hit entry is finer (up to 4 + 16 reads at
// MAX_LEVEL 2), completes each average and hands over the result.
`include "amr_grid_hash_remap_assert.svh"

module amr_grid_hash_remap (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  amr_pkg::amr_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output amr_pkg::amr_out_t out_data_o
);
  import amr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_PROBE_ISSUE, S_PROBE_WAIT,
    S_AVG_ISSUE, S_AVG_WAIT, S_AVG_ACC, S_FINISH
  } state_e;

  function automatic logic [ADDR_W-1:0] fine_addr(input logic [FINE_W-1:0] fy,
                                                  input logic [FINE_W-1:0] fx);
    fine_addr = ADDR_W'(int'(fy) * FINE_SIDE + int'(fx));
  endfunction

  state_e                  state_q;
  logic [ADDR_W-1:0]       clr_ptr_q;
  logic                    clr_reply_q;
  logic [FINE_W-1:0]       fx_q, fy_q;
  logic [LVL_W-1:0]        lev_q;
  logic [FINE_W-1:0]       sub_x_q, sub_y_q;
  logic [DEPTH_W-1:0]      depth_q;
  logic signed [SUM_W-1:0] part_q;
  logic signed [31:0]      res_q;
  logic [1:0]              stat_q;
  logic                    out_valid_q;
  amr_out_t                out_q;

  // Averaging stack, one frame per open level
  logic [FINE_W-1:0]       fy_s [STACK_DEPTH];
  logic [FINE_W-1:0]       fx_s [STACK_DEPTH];
  logic [LVL_W-1:0]        lv_s [STACK_DEPTH];
  logic [1:0]              k_s  [STACK_DEPTH];
  logic signed [SUM_W-1:0] sum_s[STACK_DEPTH];

  logic                    in_accept;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  amr_entry_t              wr_entry, rd_entry;
  logic [$bits(amr_entry_t)-1:0] rd_raw;

  logic [SHIFT_W-1:0]      lx, ly, qx, qy;
  logic [LVL_W-1:0]        q_lev;
  logic                    load_ok, query_ok;
  logic [FINE_W-1:0]       step, sy, sx;
  logic [LVL_W-1:0]        lev_top, lev_dn, drop;
  logic                    push;
  logic signed [SUM_W-1:0] nsum, avg;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign rd_entry    = amr_entry_t'(rd_raw);

  // Decode the incoming cell into fine-grid coordinates
  always_comb begin
    lx = SHIFT_W'(in_data_i.col) << (3'(MAX_LEVEL) - in_data_i.cell_level);
    ly = SHIFT_W'(in_data_i.row) << (3'(MAX_LEVEL) - in_data_i.cell_level);
    load_ok = (in_data_i.cell_level <= 3'(MAX_LEVEL)) &&
              (32'(lx) < FINE_SIDE) && (32'(ly) < FINE_SIDE);
    if (in_data_i.cell_level > 3'(MAX_LEVEL)) begin
      qx    = SHIFT_W'(in_data_i.col >> (in_data_i.cell_level - 3'(MAX_LEVEL)));
      qy    = SHIFT_W'(in_data_i.row >> (in_data_i.cell_level - 3'(MAX_LEVEL)));
      q_lev = LVL_W'(MAX_LEVEL);
    end else begin
      qx    = lx;
      qy    = ly;
      q_lev = LVL_W'(in_data_i.cell_level);
    end
    query_ok = (32'(qx) < FINE_SIDE) && (32'(qy) < FINE_SIDE);
  end

  // Subcell address of the top frame and helpers for probing
  always_comb begin
    lev_top = lv_s[depth_q];
    step    = FINE_W'(1) << (LVL_W'(MAX_LEVEL - 1) - lev_top);
    sy      = fy_s[depth_q] + (k_s[depth_q][1] ? step : '0);
    sx      = fx_s[depth_q] + (k_s[depth_q][0] ? step : '0);
    lev_dn  = lev_q - LVL_W'(1);
    drop    = LVL_W'(MAX_LEVEL) - lev_dn;
    push    = ({1'b0, rd_entry.level} > ({1'b0, lev_top} + (LVL_W+1)'(1))) &&
              (({1'b0, lev_top} + (LVL_W+1)'(1)) < (LVL_W+1)'(MAX_LEVEL));
    nsum    = sum_s[depth_q] + part_q;
    avg     = nsum >>> 2;
  end

  // Store ports: clear sweep or load on write, probe or subcell on read
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = clr_ptr_q;
    wr_entry = '0;
    if (state_q == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (in_accept && in_data_i.req_type == REQ_LOAD && load_ok) begin
      wr_en          = 1'b1;
      wr_addr        = fine_addr(FINE_W'(ly), FINE_W'(lx));
      wr_entry.valid = 1'b1;
      wr_entry.level = LVL_W'(in_data_i.cell_level);
      wr_entry.value = VALUE_BITS'(in_data_i.cell_value);
    end
    rd_addr = (state_q == S_PROBE_ISSUE) ? fine_addr(fy_q, fx_q) : fine_addr(sy, sx);
  end

  amr_ram #(
    .WIDTH($bits(amr_entry_t)),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_entry),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_raw)
  );

  // Sequencer: state, stack and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_ptr_q   <= '0;
      clr_reply_q <= 1'b0;
      out_valid_q <= 1'b0;
      depth_q     <= '0;
    end else begin
      // raise the output on hand-over, drop it once taken
      if (state_q == S_FINISH && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            res_q  <= '0;
            priority case (in_data_i.req_type)
              REQ_CLEAR: begin
                clr_ptr_q   <= '0;
                clr_reply_q <= 1'b1;
                state_q     <= S_CLEAR;
              end
              REQ_LOAD: begin
                stat_q  <= load_ok ? ST_OK : ST_BAD;
                state_q <= S_FINISH;
              end
              REQ_QUERY: begin
                if (query_ok) begin
                  fx_q    <= FINE_W'(qx);
                  fy_q    <= FINE_W'(qy);
                  lev_q   <= q_lev;
                  stat_q  <= ST_OK;
                  state_q <= S_PROBE_ISSUE;
                end else begin
                  stat_q  <= ST_BAD;
                  state_q <= S_FINISH;
                end
              end
              default: begin
                stat_q  <= ST_BAD;
                state_q <= S_FINISH;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (clr_ptr_q == ADDR_W'(STORE_DEPTH - 1)) begin
            clr_ptr_q <= '0;
            res_q     <= '0;
            stat_q    <= ST_OK;
            state_q   <= clr_reply_q ? S_FINISH : S_IDLE;
          end else begin
            clr_ptr_q <= clr_ptr_q + ADDR_W'(1);
          end
        end
        S_PROBE_ISSUE: begin
          state_q <= S_PROBE_WAIT;
        end
        S_PROBE_WAIT: begin
          if (!rd_entry.valid) begin
            if (lev_q != '0) begin
              // step to the next coarser level
              lev_q   <= lev_dn;
              fx_q    <= (fx_q >> drop) << drop;
              fy_q    <= (fy_q >> drop) << drop;
              state_q <= S_PROBE_ISSUE;
            end else begin
              stat_q  <= ST_MISS;
              state_q <= S_FINISH;
            end
          end else if (lev_q >= rd_entry.level) begin
            res_q   <= 32'(rd_entry.value);
            state_q <= S_FINISH;
          end else begin
            fy_s[0]  <= fy_q;
            fx_s[0]  <= fx_q;
            lv_s[0]  <= lev_q;
            k_s[0]   <= '0;
            sum_s[0] <= '0;
            depth_q  <= '0;
            state_q  <= S_AVG_ISSUE;
          end
        end
        S_AVG_ISSUE: begin
          sub_y_q <= sy;
          sub_x_q <= sx;
          state_q <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (!rd_entry.valid) begin
            res_q   <= '0;
            stat_q  <= ST_MISS;
            state_q <= S_FINISH;
          end else if (push) begin
            // open a frame one level finer
            depth_q                   <= depth_q + DEPTH_W'(1);
            fy_s[depth_q + DEPTH_W'(1)]  <= sub_y_q;
            fx_s[depth_q + DEPTH_W'(1)]  <= sub_x_q;
            lv_s[depth_q + DEPTH_W'(1)]  <= lev_top + LVL_W'(1);
            k_s[depth_q + DEPTH_W'(1)]   <= '0;
            sum_s[depth_q + DEPTH_W'(1)] <= '0;
            state_q                   <= S_AVG_ISSUE;
          end else begin
            part_q  <= SUM_W'(rd_entry.value);
            state_q <= S_AVG_ACC;
          end
        end
        S_AVG_ACC: begin
          if (k_s[depth_q] == 2'd3) begin
            if (depth_q == '0) begin
              res_q   <= 32'(avg);
              state_q <= S_FINISH;
            end else begin
              // close the frame and feed its average to the parent
              part_q  <= avg;
              depth_q <= depth_q - DEPTH_W'(1);
            end
          end else begin
            sum_s[depth_q] <= nsum;
            k_s[depth_q]   <= k_s[depth_q] + 2'd1;
            state_q        <= S_AVG_ISSUE;
          end
        end
        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.result_value <= res_q;
            out_q.status       <= stat_q;
            clr_reply_q        <= 1'b0;
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `AMR_ASSERT_IMPL(a_store_write_state, wr_en,
    (state_q == S_CLEAR || state_q == S_IDLE), "store written outside clear or load")
  `AMR_ASSERT_IMPL(a_error_zero_value, out_valid_q && out_q.status != ST_OK,
    out_q.result_value == '0, "nonzero value with error status")
  `AMR_ASSERT_IMPL(a_stack_bounded, state_q == S_AVG_ISSUE,
    32'(depth_q) < STACK_DEPTH, "averaging stack overflow")
  `AMR_ASSERT_NEXT(a_query_starts, in_accept && in_data_i.req_type == REQ_QUERY,
    (state_q == S_PROBE_ISSUE || state_q == S_FINISH), "query did not start")

endmodule
